[rtl/ccd_pkg.sv]
`timescale 1ns / 1ps

package ccd_pkg;

	// CRC and chunk type codes
	localparam logic [31:0] CRC_POLY  = 32'h1edc_6f41;
	localparam logic [31:0] CRC_TOP   = 32'h8000_0000;
	localparam logic [31:0] TYPE_HDR  = 32'h5042_4954;
	localparam logic [31:0] TYPE_TEXT = 32'h5445_5854;
	localparam logic [31:0] TYPE_TRAK = 32'h5452_414b;
	localparam logic [31:0] TYPE_DATA = 32'h4441_5441;
	localparam logic [31:0] TYPE_END  = 32'h454e_4420;

	// minimum payload sizes
	localparam logic [31:0] HDR_MIN_SIZE  = 32'd8;
	localparam logic [31:0] TRAK_MIN_SIZE = 32'd20;

	// field bytes of type, size and crc words
	localparam logic [31:0] WORD_BYTES = 32'd4;

	// header payload: version bytes and the byte where it is judged
	localparam logic [31:0] VERSION_BYTES = 32'd4;
	localparam logic [31:0] VERSION_CHECK = 32'd7;

	typedef enum logic [4:0] {
		PH_TYPE = 5'b00001,
		PH_SIZE = 5'b00010,
		PH_BODY = 5'b00100,
		PH_CRC  = 5'b01000,
		PH_STOP = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		RK_PAYLOAD   = 2'd0,
		RK_CHUNK_END = 2'd1,
		RK_ERROR     = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		CK_HEADER  = 3'd0,
		CK_TEXT    = 3'd1,
		CK_TRACK   = 3'd2,
		CK_DATA    = 3'd3,
		CK_END     = 3'd4,
		CK_UNKNOWN = 3'd5
	} chunk_kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_CRC_BAD     = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_DATA_FIRST  = 3'd4,
		ST_SHORT       = 3'd5
	} status_t;

	typedef struct packed {
		result_kind_t kind;
		chunk_kind_t  chunk;
		logic [7:0]   pbyte;
		logic [31:0]  offset;
		logic [31:0]  length;
		status_t      status;
		logic         done;
	} result_t;

	// MSB-first CRC update by one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 32'h0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	// chunk classification; the very first chunk is always the header
	function automatic chunk_kind_t kind_of(input logic first, input logic [31:0] tw);
		chunk_kind_t k;
		if (first) begin
			k = CK_HEADER;
		end else if (tw == TYPE_TEXT) begin
			k = CK_TEXT;
		end else if (tw == TYPE_TRAK) begin
			k = CK_TRACK;
		end else if (tw == TYPE_DATA) begin
			k = CK_DATA;
		end else if (tw == TYPE_END) begin
			k = CK_END;
		end else begin
			k = CK_UNKNOWN;
		end
		return k;
	endfunction

endpackage

[rtl/ccd_in_if.sv]
`timescale 1ns / 1ps

interface ccd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

[rtl/ccd_out_if.sv]
`timescale 1ns / 1ps

interface ccd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [2:0]  chunk_kind;
	logic [7:0]  payload_byte;
	logic [31:0] payload_offset;
	logic [31:0] chunk_length;
	logic [2:0]  status;
	logic        image_done;

	modport source (
		output valid, output result_kind, output chunk_kind, output payload_byte,
		output payload_offset, output chunk_length, output status, output image_done,
		input ready
	);
	modport sink (
		input valid, input result_kind, input chunk_kind, input payload_byte,
		input payload_offset, input chunk_length, input status, input image_done,
		output ready
	);
endinterface

[rtl/ccd_core.sv]
`timescale 1ns / 1ps

module ccd_core
	import ccd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output logic       res_valid,
	output result_t    res
);

	phase_t      phase_q, ph_e, ph_n;
	logic [31:0] cnt_q, cnt_e, cnt_n, cnt_inc;
	logic [31:0] type_q, type_e, type_n;
	logic [31:0] size_q, size_e, size_n;
	logic [31:0] crc_q, crc_e, crc_n;
	logic [31:0] rcv_q, rcv_e, rcv_n;
	logic        trk_q, trk_e, trk_n;
	logic        first_q, first_e, first_n;
	logic        vn_q, vn_e, vn_n;
	logic        emit;
	logic        crc_ok;
	chunk_kind_t k;

	// restart clears the parser before the word is taken
	always_comb begin
		ph_e    = restart ? PH_TYPE : phase_q;
		cnt_e   = restart ? 32'h0 : cnt_q;
		type_e  = restart ? 32'h0 : type_q;
		size_e  = restart ? 32'h0 : size_q;
		crc_e   = restart ? 32'h0 : crc_q;
		rcv_e   = restart ? 32'h0 : rcv_q;
		trk_e   = restart ? 1'b0 : trk_q;
		first_e = restart ? 1'b1 : first_q;
		vn_e    = restart ? 1'b0 : vn_q;
	end

	assign k       = kind_of(first_e, type_e);
	assign cnt_inc = cnt_e + 32'd1;

	// phase machine and result selection
	always_comb begin
		ph_n    = ph_e;
		cnt_n   = cnt_e;
		type_n  = type_e;
		size_n  = size_e;
		crc_n   = crc_e;
		rcv_n   = rcv_e;
		trk_n   = trk_e;
		first_n = first_e;
		vn_n    = vn_e;
		emit    = 1'b0;
		crc_ok  = 1'b0;
		res.kind   = RK_PAYLOAD;
		res.chunk  = k;
		res.pbyte  = 8'h0;
		res.offset = 32'h0;
		res.status = ST_OK;
		res.done   = 1'b0;
		case (ph_e)
			PH_TYPE: begin
				type_n = {type_e[23:0], data_byte};
				crc_n  = crc_byte(crc_e, data_byte);
				cnt_n  = cnt_inc;
				if (cnt_inc == WORD_BYTES) begin
					cnt_n = 32'h0;
					if (first_e && type_n != TYPE_HDR) begin
						ph_n       = PH_STOP;
						emit       = 1'b1;
						res.kind   = RK_ERROR;
						res.chunk  = CK_UNKNOWN;
						res.status = ST_BAD_MAGIC;
					end else begin
						ph_n = PH_SIZE;
					end
				end
			end
			PH_SIZE: begin
				size_n = {size_e[23:0], data_byte};
				crc_n  = crc_byte(crc_e, data_byte);
				cnt_n  = cnt_inc;
				if (cnt_inc == WORD_BYTES) begin
					cnt_n = 32'h0;
					if ((k == CK_HEADER && size_n < HDR_MIN_SIZE) ||
						(k == CK_TRACK && size_n < TRAK_MIN_SIZE)) begin
						ph_n       = PH_STOP;
						emit       = 1'b1;
						res.kind   = RK_ERROR;
						res.status = ST_SHORT;
					end else if (k == CK_DATA && !trk_e) begin
						ph_n       = PH_STOP;
						emit       = 1'b1;
						res.kind   = RK_ERROR;
						res.status = ST_DATA_FIRST;
					end else begin
						if (k == CK_TRACK) begin
							trk_n = 1'b1;
						end
						ph_n = (size_n == 32'h0) ? PH_CRC : PH_BODY;
					end
				end
			end
			PH_BODY: begin
				crc_n = crc_byte(crc_e, data_byte);
				if (k == CK_HEADER && cnt_e < VERSION_BYTES && data_byte != 8'h0) begin
					vn_n = 1'b1;
				end
				emit = 1'b1;
				if (k == CK_HEADER && cnt_e == VERSION_CHECK && vn_n) begin
					ph_n       = PH_STOP;
					res.kind   = RK_ERROR;
					res.status = ST_BAD_VERSION;
				end else begin
					res.pbyte  = data_byte;
					res.offset = cnt_e;
					if (cnt_inc == size_e) begin
						cnt_n = 32'h0;
						ph_n  = PH_CRC;
					end else begin
						cnt_n = cnt_inc;
					end
				end
			end
			PH_CRC: begin
				rcv_n = {rcv_e[23:0], data_byte};
				cnt_n = cnt_inc;
				if (cnt_inc == WORD_BYTES) begin
					crc_ok     = (rcv_n == crc_e);
					emit       = 1'b1;
					res.kind   = RK_CHUNK_END;
					res.status = crc_ok ? ST_OK : ST_CRC_BAD;
					res.done   = crc_ok && k == CK_END;
					if (!crc_ok || k == CK_END) begin
						ph_n = PH_STOP;
					end else begin
						ph_n    = PH_TYPE;
						cnt_n   = 32'h0;
						type_n  = 32'h0;
						size_n  = 32'h0;
						crc_n   = 32'h0;
						rcv_n   = 32'h0;
						first_n = 1'b0;
					end
				end
			end
			default: begin
				// stopped: words are dropped until restart
			end
		endcase
		// chunk end reports the size of the chunk it closes
		res.length = (ph_e == PH_CRC) ? size_e : size_n;
	end

	assign res_valid = accept && emit;

	// parser state, advanced on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			cnt_q   <= 32'h0;
			type_q  <= 32'h0;
			size_q  <= 32'h0;
			crc_q   <= 32'h0;
			rcv_q   <= 32'h0;
			trk_q   <= 1'b0;
			first_q <= 1'b1;
			vn_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= ph_n;
			cnt_q   <= cnt_n;
			type_q  <= type_n;
			size_q  <= size_n;
			crc_q   <= crc_n;
			rcv_q   <= rcv_n;
			trk_q   <= trk_n;
			first_q <= first_n;
			vn_q    <= vn_n;
		end
	end

	// a stopped parser stays silent until restart
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart && phase_q == PH_STOP |-> !res_valid)
		else $error("result produced while stopped");

	// every error result leaves the parser stopped
	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == RK_ERROR |=> phase_q == PH_STOP)
		else $error("error result did not stop the parser");

	// image_done only on a good chunk end
	a_done_good: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done |-> res.kind == RK_CHUNK_END && res.status == ST_OK &&
			res.chunk == CK_END)
		else $error("image_done on a bad or non-end result");

	// word counter stays within a field while a type, size or crc field is read
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TYPE || phase_q == PH_SIZE || phase_q == PH_CRC |->
			cnt_q <= WORD_BYTES)
		else $error("field counter out of range");

endmodule

[rtl/ccd_out_stage.sv]
`timescale 1ns / 1ps

module ccd_out_stage
	import ccd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  result_t      res_in,
	output logic         free,
	ccd_out_if.source    result
);

	logic    valid_q;
	result_t data_q;

	// slot is free when empty or being drained this cycle
	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_in;
		end
	end

	assign result.valid          = valid_q;
	assign result.result_kind    = data_q.kind;
	assign result.chunk_kind     = data_q.chunk;
	assign result.payload_byte   = data_q.pbyte;
	assign result.payload_offset = data_q.offset;
	assign result.chunk_length   = data_q.length;
	assign result.status         = data_q.status;
	assign result.image_done     = data_q.done;

endmodule

[rtl/crc_checked_chunk_deframer_unit.sv]
`timescale 1ns / 1ps

// Chunk deframer for a CRC-checked image stream, one byte per word. Each chunk
// is a big-endian type, size, payload and CRC (MSB-first, poly 0x1edc6f41,
// seed zero, over type, size and payload). Payload bytes come out with their
// offset, each chunk end gives its CRC status, and protocol errors or a CRC
// mismatch give one error or end word after which input is dropped until a
// word arrives with restart set; restart clears the parser before that byte
// is used. An end chunk with good CRC sets image_done and also stops the
// parser. Throughput is one byte per clock while the output is not stalled:
// each byte goes through a single byte-wide CRC update and the phase machine
// in the cycle it is accepted, and its result (if any) is loaded into the
// output register at that same edge, so it is offered on the next cycle.
// Input ready follows result ready whenever the output register holds a word.
module crc_checked_chunk_deframer_unit
	import ccd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ccd_in_if.sink    stream,
	ccd_out_if.source result
);

	logic    accept;
	logic    res_valid;
	logic    free;
	result_t res;

	assign stream.ready = free;
	assign accept       = stream.valid && free;

	ccd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (stream.data_byte),
		.restart   (stream.restart),
		.res_valid (res_valid),
		.res       (res)
	);

	ccd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res_in (res),
		.free   (free),
		.result (result)
	);

endmodule
